// ===== hw/rtl/ivalu_pkg.sv =====
// ----------------------------------------------------------------------------
// ivalu_pkg: shared types and helpers for the 16-bit VM ALU
// Opcode codes, pipeline stage record and the restoring divide step.
// ----------------------------------------------------------------------------
package ivalu_pkg;

	localparam int WordW  = 16;
	localparam int DivBitsPerStage = 4;

	typedef enum logic [3:0] {
		OP_ADD    = 4'd0,
		OP_SUB    = 4'd1,
		OP_MUL    = 4'd2,
		OP_DIV    = 4'd3,
		OP_MOD    = 4'd4,
		OP_AND    = 4'd5,
		OP_OR     = 4'd6,
		OP_NOT    = 4'd7,
		OP_ASHIFT = 4'd8,
		OP_LSHIFT = 4'd9,
		OP_JE     = 4'd10,
		OP_JG     = 4'd11,
		OP_JL     = 4'd12,
		OP_JZ     = 4'd13,
		OP_TEST   = 4'd14,
		OP_NOP    = 4'd15
	} op_t;

	typedef struct packed {
		logic             valid;
		logic [WordW-1:0] val;
		logic             br;
		logic             taken;
		logic             err;
		logic             is_div;
		logic             is_mod;
		logic             q_neg;
		logic             r_neg;
		logic [WordW-1:0] rem;
		logic [WordW-1:0] dq;
		logic [WordW-1:0] dv;
	} pipe_t;

	// one restoring step: {rem, dq} with the next quotient bit shifted into dq
	function automatic logic [2*WordW-1:0] div_step(logic [WordW-1:0] rem,
			logic [WordW-1:0] dq, logic [WordW-1:0] dv);
		logic [WordW:0] r2;
		logic [WordW:0] df;
		r2 = {rem, dq[WordW-1]};
		df = r2 - {1'b0, dv};
		if (!df[WordW]) begin
			return {df[WordW-1:0], dq[WordW-2:0], 1'b1};
		end
		return {r2[WordW-1:0], dq[WordW-2:0], 1'b0};
	endfunction

	function automatic pipe_t div_stage(pipe_t p);
		pipe_t r;
		logic [2*WordW-1:0] t;
		r = p;
		for (int i = 0; i < DivBitsPerStage; i++) begin
			t = div_step(r.rem, r.dq, r.dv);
			r.rem = t[2*WordW-1:WordW];
			r.dq  = t[WordW-1:0];
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/interpreter_vm_alu_16bit_core.sv =====
// ----------------------------------------------------------------------------
// interpreter_vm_alu_16bit_core: 16-bit VM arithmetic and branch unit
// Decode stage, four radix-2 divide stages of four bits each, output register.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle; the whole pipe stalls while m_tvalid
// is high and m_tready is low. The 16-step divide is spread over four stages.
// Reset: arst_n clears all stage valid bits and the output valid.
module interpreter_vm_alu_16bit_core
	import ivalu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [3:0] opcode, [19:4] operand_a, [35:20] operand_b, [51:36] operand_c,
	// [67:52] operand_d, [70:68] arg_count, [71] zero
	input  logic [71:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [15:0] store_value, [16] branch_taken, [17] divide_error, [23:18] zero
	output logic [23:0] m_tdata,
	// [0] is_branch
	output logic        m_tuser
);

	logic adv;
	pipe_t nxt_s1, p_s1, p_s2, p_s3, p_s4, p_s5;
	logic [23:0] data_q;
	logic        user_q;
	logic        valid_q;

	assign adv      = !valid_q || m_tready;
	assign s_tready = adv;

	// decode stage
	always_comb begin
		op_t op;
		logic [15:0] a, b, c, d, mag, mb;
		logic [2:0] n;
		logic [31:0] prod;
		op = op_t'(s_tdata[3:0]);
		a  = s_tdata[19:4];
		b  = s_tdata[35:20];
		c  = s_tdata[51:36];
		d  = s_tdata[67:52];
		n  = s_tdata[70:68];
		prod = a * b;
		mag  = ~b + 16'd1;
		mb   = b[15] ? mag : b;
		nxt_s1 = '0;
		nxt_s1.valid = s_tvalid;
		nxt_s1.dv    = b[15] ? mag : b;
		nxt_s1.dq    = a[15] ? (~a + 16'd1) : a;
		nxt_s1.q_neg = a[15] ^ b[15];
		nxt_s1.r_neg = a[15];
		unique case (op)
			OP_ADD: nxt_s1.val = a + b;
			OP_SUB: nxt_s1.val = a - b;
			OP_MUL: nxt_s1.val = prod[15:0];
			OP_DIV, OP_MOD: begin
				if (b == 16'd0) begin
					nxt_s1.err = 1'b1;
				end else begin
					nxt_s1.is_div = (op == OP_DIV);
					nxt_s1.is_mod = (op == OP_MOD);
				end
			end
			OP_AND: nxt_s1.val = a & b;
			OP_OR:  nxt_s1.val = a | b;
			OP_NOT: nxt_s1.val = ~a;
			OP_ASHIFT, OP_LSHIFT: begin
				// positive count shifts left, zero or negative shifts right
				if (!b[15] && b != 16'd0) begin
					nxt_s1.val = (mb >= 16'd16) ? 16'd0 : (a << mb[3:0]);
				end else if (op == OP_ASHIFT) begin
					nxt_s1.val = (mb >= 16'd16) ? {16{a[15]}}
						: 16'($signed(a) >>> mb[3:0]);
				end else begin
					nxt_s1.val = (mb >= 16'd16) ? 16'd0 : (a >> mb[3:0]);
				end
			end
			OP_JE: begin
				nxt_s1.br = 1'b1;
				nxt_s1.taken = (n > 3'd1 && a == b) || (n > 3'd2 && a == c)
					|| (n > 3'd3 && a == d);
			end
			OP_JG: begin
				nxt_s1.br = 1'b1;
				nxt_s1.taken = $signed(a) > $signed(b);
			end
			OP_JL: begin
				nxt_s1.br = 1'b1;
				nxt_s1.taken = $signed(a) < $signed(b);
			end
			OP_JZ: begin
				nxt_s1.br = 1'b1;
				nxt_s1.taken = (a == 16'd0);
			end
			OP_TEST: begin
				nxt_s1.br = 1'b1;
				nxt_s1.taken = ((a & b) == b);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_s1.valid <= 1'b0;
			p_s2.valid <= 1'b0;
			p_s3.valid <= 1'b0;
			p_s4.valid <= 1'b0;
			p_s5.valid <= 1'b0;
			valid_q    <= 1'b0;
		end else if (adv) begin
			p_s1 <= nxt_s1;
			p_s2 <= div_stage(p_s1);
			p_s3 <= div_stage(p_s2);
			p_s4 <= div_stage(p_s3);
			p_s5 <= div_stage(p_s4);
			valid_q <= p_s5.valid;
		end
	end

	// sign fix and result select
	always_ff @(posedge clk) begin
		if (adv) begin
			data_q[23:18] <= '0;
			if (p_s5.is_div) begin
				data_q[15:0] <= p_s5.q_neg ? (~p_s5.dq + 16'd1) : p_s5.dq;
			end else if (p_s5.is_mod) begin
				data_q[15:0] <= p_s5.r_neg ? (~p_s5.rem + 16'd1) : p_s5.rem;
			end else begin
				data_q[15:0] <= p_s5.val;
			end
			data_q[16] <= p_s5.taken;
			data_q[17] <= p_s5.err;
			user_q     <= p_s5.br;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = user_q;

endmodule

// ===== tb/tb_interpreter_vm_alu_16bit_core.sv =====
// ----------------------------------------------------------------------------
// tb_interpreter_vm_alu_16bit_core: self-checking bench for the VM ALU
// Directed corner instructions, then random instruction streams with
// receiver stalls and, mostly, random sender gaps. Every output word is
// compared field by field with an in-bench prediction.
// ----------------------------------------------------------------------------
module tb_interpreter_vm_alu_16bit_core;
	import ivalu_pkg::*;

	typedef struct {
		logic [15:0] value;
		logic        branch;
		logic        taken;
		logic        div_err;
	} alu_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic        m_tuser;

	alu_result_t pending_results[$];
	int          error_count;
	bit          long_stall_req;
	bit          sender_gaps;

	interpreter_vm_alu_16bit_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [15:0] shift_word(logic [15:0] val, logic [15:0] cnt,
			bit arith);
		int c;
		int mag;
		logic [15:0] fill;
		c = $signed(cnt);
		fill = (arith && val[15]) ? 16'hFFFF : 16'h0000;
		if (c > 0) begin
			if (c >= 16) return 16'h0000;
			return val << c;
		end
		mag = -c;
		if (mag >= 16) return fill;
		if (arith) return $signed(val) >>> mag;
		return val >> mag;
	endfunction

	function automatic alu_result_t alu_predict(op_t op, logic [15:0] a, logic [15:0] b,
			logic [15:0] c, logic [15:0] d, logic [2:0] n);
		alu_result_t r;
		int sa;
		int sb;
		sa = $signed(a);
		sb = $signed(b);
		r = '{16'h0, 1'b0, 1'b0, 1'b0};
		case (op)
			OP_ADD: r.value = a + b;
			OP_SUB: r.value = a - b;
			OP_MUL: r.value = a * b;
			OP_DIV, OP_MOD: begin
				if (b == 16'h0) r.div_err = 1'b1;
				else if (op == OP_DIV) r.value = 16'(sa / sb);
				else r.value = 16'(sa % sb);
			end
			OP_AND: r.value = a & b;
			OP_OR: r.value = a | b;
			OP_NOT: r.value = ~a;
			OP_ASHIFT: r.value = shift_word(a, b, 1'b1);
			OP_LSHIFT: r.value = shift_word(a, b, 1'b0);
			OP_JE: begin
				r.branch = 1'b1;
				r.taken = (n > 1 && a == b) || (n > 2 && a == c) || (n > 3 && a == d);
			end
			OP_JG: begin r.branch = 1'b1; r.taken = sa > sb; end
			OP_JL: begin r.branch = 1'b1; r.taken = sa < sb; end
			OP_JZ: begin r.branch = 1'b1; r.taken = a == 16'h0; end
			OP_TEST: begin r.branch = 1'b1; r.taken = (a & b) == b; end
			default: ;
		endcase
		return r;
	endfunction

	// one instruction word; returns once it is accepted
	task automatic send_instr(op_t op, logic [15:0] a, logic [15:0] b, logic [15:0] c,
			logic [15:0] d, logic [2:0] n);
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, n, d, c, b, a, op};
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(alu_predict(op, a, b, c, d, n));
		if (sender_gaps && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	function automatic logic [15:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			3: return 16'h7FFF;
			4: return 16'($signed($urandom_range(0, 40)) - 20);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic test_directed();
		send_instr(OP_ADD, 16'hFFFF, 16'h0001, 16'h0000, 16'h0000, 3'd1);
		send_instr(OP_SUB, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 3'd1);
		send_instr(OP_MUL, 16'h8000, 16'hFFFF, 16'h0000, 16'h0000, 3'd1);
		send_instr(OP_DIV, 16'h8000, 16'hFFFF, 16'h0000, 16'h0000, 3'd1);
		send_instr(OP_MOD, 16'h8000, 16'hFFFF, 16'h0000, 16'h0000, 3'd1);
		send_instr(OP_DIV, 16'h1234, 16'h0000, 16'h0000, 16'h0000, 3'd1);
		send_instr(OP_MOD, 16'hFFF9, 16'h0000, 16'h0000, 16'h0000, 3'd1);
		send_instr(OP_DIV, 16'hFFF9, 16'h0002, 16'h0000, 16'h0000, 3'd1);
		send_instr(OP_MOD, 16'hFFF9, 16'h0002, 16'h0000, 16'h0000, 3'd1);
		send_instr(OP_AND, 16'hA5A5, 16'hFFFF, 16'h0000, 16'h0000, 3'd1);
		send_instr(OP_OR, 16'hA5A5, 16'h5A5A, 16'h0000, 16'h0000, 3'd1);
		send_instr(OP_NOT, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 3'd1);
		send_instr(OP_ASHIFT, 16'h8001, 16'hFFF0, 16'h0000, 16'h0000, 3'd1);
		send_instr(OP_ASHIFT, 16'h8001, 16'h8000, 16'h0000, 16'h0000, 3'd1);
		send_instr(OP_ASHIFT, 16'h8001, 16'h0000, 16'h0000, 16'h0000, 3'd1);
		send_instr(OP_LSHIFT, 16'h8001, 16'h0010, 16'h0000, 16'h0000, 3'd1);
		send_instr(OP_LSHIFT, 16'h8001, 16'hFFFF, 16'h0000, 16'h0000, 3'd1);
		send_instr(OP_LSHIFT, 16'h8001, 16'h000F, 16'h0000, 16'h0000, 3'd1);
		send_instr(OP_JE, 16'h0007, 16'h0007, 16'h0007, 16'h0007, 3'd1);
		send_instr(OP_JE, 16'h0007, 16'h0001, 16'h0002, 16'h0007, 3'd7);
		send_instr(OP_JE, 16'h0007, 16'h0001, 16'h0007, 16'h0000, 3'd0);
		send_instr(OP_JG, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 3'd1);
		send_instr(OP_JL, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 3'd1);
		send_instr(OP_JZ, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 3'd1);
		send_instr(OP_TEST, 16'hF0F0, 16'h0000, 16'h0000, 16'h0000, 3'd1);
		send_instr(OP_NOP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7);
	endtask

	task automatic test_random(int count);
		logic [15:0] a;
		logic [15:0] b;
		logic [15:0] c;
		logic [15:0] d;
		for (int i = 0; i < count; i++) begin
			a = rand_word();
			b = rand_word();
			c = ($urandom_range(0, 2) == 0) ? a : rand_word();
			d = ($urandom_range(0, 2) == 0) ? a : rand_word();
			if ($urandom_range(0, 3) == 0) b = a;
			send_instr(op_t'($urandom_range(0, 15)), a, b, c, d, 3'($urandom));
		end
	endtask

	// receiver held off while the sender keeps pushing, so the pipe backs up
	task automatic test_backpressure();
		long_stall_req = 1'b1;
		test_random(60);
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		error_count = 0;
		long_stall_req = 1'b0;
		sender_gaps = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		wait_drained();
		sender_gaps = 1'b1;
		test_random(600);
		test_backpressure();
		sender_gaps = 1'b0;
		test_random(200);
		sender_gaps = 1'b1;
		test_random(400);
		wait_drained();
		if (error_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// receiver: stall pattern, plus one long hold-off on request
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_stall_req) begin
				long_stall_req = 1'b0;
				m_tready <= 1'b0;
				repeat (200) @(posedge clk);
			end
			case ($urandom_range(0, 3))
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				2: m_tready <= 1'($urandom_range(0, 1));
				default: m_tready <= ($urandom_range(0, 4) == 0);
			endcase
		end
	end

	// result checker
	always @(posedge clk) begin
		alu_result_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected word %h user %b", $time, m_tdata, m_tuser);
				error_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (m_tdata[15:0] !== exp_r.value) begin
					$display("%0t: store_value exp %h got %h", $time, exp_r.value,
						m_tdata[15:0]);
					error_count++;
				end
				if (m_tuser !== exp_r.branch) begin
					$display("%0t: is_branch exp %b got %b", $time, exp_r.branch, m_tuser);
					error_count++;
				end
				if (m_tdata[16] !== exp_r.taken) begin
					$display("%0t: branch_taken exp %b got %b", $time, exp_r.taken,
						m_tdata[16]);
					error_count++;
				end
				if (m_tdata[17] !== exp_r.div_err) begin
					$display("%0t: divide_error exp %b got %b", $time, exp_r.div_err,
						m_tdata[17]);
					error_count++;
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
